// ===== design/lacu_pkg.sv =====
package lacu_pkg;

   // Fixed-point formats: values Q16.16, coefficients Q2.30
   localparam int DATA_W    = 32;
   localparam int COEF_FRAC = 30;
   localparam int PROD_W    = 65;                  // covers 32 x 33 signed products
   localparam int RND_W     = PROD_W - COEF_FRAC;  // rounded product, Q16.16 with headroom
   localparam int SUM_W     = RND_W + 1;           // exact sum of two rounded terms
   localparam int DRIVE_W   = DATA_W + 1;          // field minus accumulator

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam int MAX_POLES_DEF = 4;
   localparam int MAX_CELLS_DEF = 4096;

   localparam int POLE_W = 2;
   localparam int CELL_W = 12;
   localparam int COMP_W = 2;
   localparam int EN_W   = 4;

   localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

   typedef enum logic [1:0] {
      CSR_VOLT_POLE_EN = 2'd0,
      CSR_CURR_POLE_EN = 2'd1,
      CSR_VOLT_LOR_EN  = 2'd2,
      CSR_CURR_LOR_EN  = 2'd3
   } csr_index_type;

   // One store word: Lorentz accumulator and ADE value of one cell/pole/component
   typedef struct packed {
      logic signed [DATA_W-1:0] lor;
      logic signed [DATA_W-1:0] ade;
   } entry_type;

   typedef struct packed {
      logic clip;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic busy;
   } store_status_type;

   // Add one half, floor shift by the coefficient fraction
   function automatic logic signed [RND_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] s;
      s = p + (PROD_W'(1) << (COEF_FRAC - 1));
      return s[PROD_W-1:COEF_FRAC];
   endfunction

   // Clip to the signed data range
   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type r;
      r.clip = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
      if (r.clip) begin
         r.val = v[SUM_W-1] ? DATA_MIN : DATA_MAX;
      end else begin
         r.val = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/lorentz_ade_cell_update_top.sv =====
// ADE cell update for a dispersive FDTD material (Lorentz/Drude poles).
// Input channel req_*: one item per cell, pole and field component; req_op
// picks the voltage side (0) or the current side (1), each with its own half of the store.
// Result channel rsp_*: the new ADE value, the new Lorentz accumulator (zero
// when the pole's Lorentz bit is clear) and a clip flag.  Items whose pole is
// disabled, or whose pole, cell or component is out of range, are taken and
// give no result.
// Configuration channel csr_*: four 4-bit enable registers, always ready;
// write them only while no item is in flight.
// An item passes stage registers 1 to 6 in turn; rsp_valid is the stage 6 valid.
// Throughput: one item per cycle, unless rsp_ready stalls, the store sweep runs or an
// item waits on a hazard.  An item that hits the same store entry as an item still in
// the second to fifth stage waits in the first stage until that item has written back;
// the ADE recurrence through the store sets this.
// Reset: the store is swept to zero one entry per cycle over all 2*MAX_POLES*
// MAX_CELLS*3 entries (98304 by default); req_ready stays low meanwhile.
// Stall: with rsp_ready low the pipeline fills and then drops req_ready;
// nothing is lost or repeated.
module lorentz_ade_cell_update_top import lacu_pkg::*; #(
   parameter int MAX_POLES = MAX_POLES_DEF,
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // input item
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [POLE_W-1:0]        req_pole,
   input  logic [CELL_W-1:0]        req_cell_req,
   input  logic [COMP_W-1:0]        req_component,
   input  logic signed [DATA_W-1:0] req_field_value,
   input  logic signed [DATA_W-1:0] req_coef_int,
   input  logic signed [DATA_W-1:0] req_coef_ext,
   input  logic signed [DATA_W-1:0] req_coef_lor,
   // result item
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_ade_value,
   output logic signed [DATA_W-1:0] rsp_lor_value,
   output logic                     rsp_saturated,
   // configuration writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [EN_W-1:0]          csr_data
);

   localparam int STORE_DEPTH = MAX_POLES * MAX_CELLS * 3;
   localparam int MEM_DEPTH   = 2 * STORE_DEPTH;
   localparam int AW          = $clog2(MEM_DEPTH);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [EN_W-1:0] volt_pen_ff, curr_pen_ff, volt_len_ff, curr_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_pen_ff <= '0;
         curr_pen_ff <= '0;
         volt_len_ff <= '0;
         curr_len_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VOLT_POLE_EN: volt_pen_ff <= csr_data;
            CSR_CURR_POLE_EN: curr_pen_ff <= csr_data;
            CSR_VOLT_LOR_EN:  volt_len_ff <= csr_data;
            CSR_CURR_LOR_EN:  curr_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline registers
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;
   logic hazard;

   // stage 1: decoded item
   logic [AW-1:0]            addr1_ff;
   logic                     len1_ff;
   logic signed [DATA_W-1:0] field1_ff, cint1_ff, cext1_ff, clor1_ff;
   // stage 2: store word read
   logic [AW-1:0]            addr2_ff;
   logic                     len2_ff;
   logic signed [DATA_W-1:0] field2_ff, cint2_ff, cext2_ff, clor2_ff;
   // stage 3: decay and Lorentz products
   logic [AW-1:0]            addr3_ff;
   logic                     len3_ff;
   logic signed [DATA_W-1:0] field3_ff, cext3_ff, lor_old3_ff;
   logic signed [PROD_W-1:0] plor3_ff, pint3_ff;
   // stage 4: accumulator and drive
   logic [AW-1:0]            addr4_ff;
   logic signed [DATA_W-1:0] cext4_ff, lor_out4_ff, lor_wb4_ff;
   logic signed [DRIVE_W-1:0] drive4_ff;
   logic signed [RND_W-1:0]  pintr4_ff;
   logic                     clipl4_ff;
   // stage 5: excitation product
   logic [AW-1:0]            addr5_ff;
   logic signed [PROD_W-1:0] pext5_ff;
   logic signed [RND_W-1:0]  pintr5_ff;
   logic signed [DATA_W-1:0] lor_out5_ff, lor_wb5_ff;
   logic                     clipl5_ff;
   // stage 6: output register
   logic signed [DATA_W-1:0] ade6_ff, lor6_ff;
   logic                     sat6_ff;

   store_status_type st_status;
   entry_type        rd_entry;
   entry_type        wr_entry;
   logic             wr_en;

   // Handshake chain: a stage loads when it is empty or its item moves on
   always_comb begin
      en6    = !v6_ff || rsp_ready;
      en5    = !v5_ff || en6;
      en4    = !v4_ff || en5;
      en3    = !v3_ff || en4;
      en2    = !v2_ff || en3;
      // hold the item in stage 1 while an older item to the same entry is
      // still ahead of its write-back
      hazard = v1_ff && ((v2_ff && addr2_ff == addr1_ff) ||
                         (v3_ff && addr3_ff == addr1_ff) ||
                         (v4_ff && addr4_ff == addr1_ff) ||
                         (v5_ff && addr5_ff == addr1_ff));
      en1    = !v1_ff || (en2 && !hazard);
   end

   assign req_ready = en1 && !st_status.busy;

   // ---------------------------------------------------------------------
   // Stage 0 -> 1: range checks, enables and store address
   // ---------------------------------------------------------------------
   logic [EN_W-1:0] pen0, len0;
   logic            item_ok0;
   logic [AW-1:0]   row0, addr0;

   always_comb begin
      pen0     = req_op ? curr_pen_ff : volt_pen_ff;
      len0     = req_op ? curr_len_ff : volt_len_ff;
      item_ok0 = (32'(req_pole) < 32'(MAX_POLES)) &&
                 (32'(req_cell_req) < 32'(MAX_CELLS)) &&
                 (req_component <= COMP_Z) && pen0[req_pole];
      row0     = AW'(req_pole) * AW'(MAX_CELLS) + AW'(req_cell_req);
      // (pole*cells + cell)*3 + component, current side in the upper half
      addr0    = (row0 << 1) + row0 + AW'(req_component) +
                 (req_op ? AW'(STORE_DEPTH) : AW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid && req_ready && item_ok0;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         addr1_ff  <= addr0;
         len1_ff   <= len0[req_pole];
         field1_ff <= req_field_value;
         cint1_ff  <= req_coef_int;
         cext1_ff  <= req_coef_ext;
         clor1_ff  <= req_coef_lor;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 -> 2: store read (registered in the store)
   // ---------------------------------------------------------------------
   lacu_store #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (en2),
      .rd_addr (addr1_ff),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (addr5_ff),
      .wr_data (wr_entry),
      .status  (st_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff && !hazard;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         addr2_ff  <= addr1_ff;
         len2_ff   <= len1_ff;
         field2_ff <= field1_ff;
         cint2_ff  <= cint1_ff;
         cext2_ff  <= cext1_ff;
         clor2_ff  <= clor1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2 -> 3: c_lor*ade and ade*c_int
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0] plor3_in, pint3_in;

   assign plor3_in = clor2_ff * rd_entry.ade;
   assign pint3_in = rd_entry.ade * cint2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         addr3_ff    <= addr2_ff;
         len3_ff     <= len2_ff;
         field3_ff   <= field2_ff;
         cext3_ff    <= cext2_ff;
         lor_old3_ff <= rd_entry.lor;
         plor3_ff    <= plor3_in;
         pint3_ff    <= pint3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3 -> 4: new accumulator, saturate, drive = field - lor
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0]   lor_sum3;
   sat_type                   lor_sat3;
   logic signed [DATA_W-1:0]  lor_out4_in, lor_wb4_in;
   logic signed [DRIVE_W-1:0] drive4_in;

   always_comb begin
      lor_sum3    = SUM_W'(lor_old3_ff) + SUM_W'(round_q30(plor3_ff));
      lor_sat3    = sat32(lor_sum3);
      // Lorentz term off: report zero and leave the stored accumulator alone
      lor_out4_in = len3_ff ? lor_sat3.val : '0;
      lor_wb4_in  = len3_ff ? lor_sat3.val : lor_old3_ff;
      drive4_in   = DRIVE_W'(field3_ff) - DRIVE_W'(lor_out4_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         addr4_ff    <= addr3_ff;
         cext4_ff    <= cext3_ff;
         lor_out4_ff <= lor_out4_in;
         lor_wb4_ff  <= lor_wb4_in;
         drive4_ff   <= drive4_in;
         pintr4_ff   <= round_q30(pint3_ff);
         clipl4_ff   <= len3_ff && lor_sat3.clip;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4 -> 5: c_ext*drive
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0] pext5_in;

   assign pext5_in = cext4_ff * drive4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         addr5_ff    <= addr4_ff;
         pext5_ff    <= pext5_in;
         pintr5_ff   <= pintr4_ff;
         lor_out5_ff <= lor_out4_ff;
         lor_wb5_ff  <= lor_wb4_ff;
         clipl5_ff   <= clipl4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5 -> 6: new ADE value, saturate, write back, present result
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] ade_sum5;
   sat_type                 ade_sat5;

   always_comb begin
      ade_sum5     = SUM_W'(pintr5_ff) + SUM_W'(round_q30(pext5_ff));
      ade_sat5     = sat32(ade_sum5);
      wr_entry.lor = lor_wb5_ff;
      wr_entry.ade = ade_sat5.val;
      // write back as the item moves into the output register
      wr_en        = v5_ff && en6;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en6) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         ade6_ff <= ade_sat5.val;
         lor6_ff <= lor_out5_ff;
         sat6_ff <= ade_sat5.clip || clipl5_ff;
      end
   end

   assign rsp_valid     = v6_ff;
   assign rsp_ade_value = ade6_ff;
   assign rsp_lor_value = lor6_ff;
   assign rsp_saturated = sat6_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // items between the read and the write-back never share a store entry
   a_no_shared_entry: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> !((v3_ff && addr3_ff == addr2_ff) ||
                  (v4_ff && addr4_ff == addr2_ff) ||
                  (v5_ff && addr5_ff == addr2_ff)))
      else $error("two in-flight items share a store entry");

   // no item is taken while the zero sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      st_status.busy |-> !req_ready)
      else $error("item accepted during store clear");

   // clip flag only with a value pinned at a range limit
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_ade_value == DATA_MAX || rsp_ade_value == DATA_MIN ||
          rsp_lor_value == DATA_MAX || rsp_lor_value == DATA_MIN))
      else $error("saturated flag without a clipped value");

   // a write-back happens only as a valid item enters the output register
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> v6_ff)
      else $error("store write without a result");

endmodule

// ===== design/lacu_store.sv =====
module lacu_store import lacu_pkg::*; #(
   parameter int DEPTH = 2 * MAX_POLES_DEF * MAX_CELLS_DEF * 3,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  entry_type        wr_data,
   output store_status_type status
);

   entry_type      mem [DEPTH];
   entry_type      rd_data_ff;
   logic           clr_busy_ff;
   logic [AW-1:0]  clr_addr_ff;
   logic           we;
   logic [AW-1:0]  waddr;
   entry_type      wdata;

   // Zero sweep after reset owns the write port
   always_comb begin
      we    = clr_busy_ff || wr_en;
      waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
      wdata = clr_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data     = rd_data_ff;
   assign status.busy = clr_busy_ff;

endmodule
